@@ design/suvm_pkg.sv @@
package suvm_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int NOW_BITS    = 64;
	localparam int FILTER_BITS = 40;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = FILTER_BITS;

	localparam logic [SAMPLE_BITS-1:0] VSUP_FALL_RST = SAMPLE_BITS'(3500);
	localparam logic [SAMPLE_BITS-1:0] VSUP_RISE_RST = SAMPLE_BITS'(3850);
	localparam logic [SAMPLE_BITS-1:0] VCC_FALL_RST  = SAMPLE_BITS'(4250);
	localparam logic [SAMPLE_BITS-1:0] VCC_RISE_RST  = SAMPLE_BITS'(4400);
	localparam logic [SAMPLE_BITS-1:0] VIO_FALL_RST  = SAMPLE_BITS'(1300);
	localparam logic [SAMPLE_BITS-1:0] VIO_RISE_RST  = SAMPLE_BITS'(1560);
	localparam logic [FILTER_BITS-1:0] FILTER_RST    = FILTER_BITS'(100000000);

	// previous sample seed, nominal rail voltage
	localparam logic [SAMPLE_BITS-1:0] VCC_LAST_RST  = SAMPLE_BITS'(5000);
	localparam logic [SAMPLE_BITS-1:0] VIO_LAST_RST  = SAMPLE_BITS'(3300);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_VSUP_FALL = 3'd0,
		REG_VSUP_RISE = 3'd1,
		REG_VCC_FALL  = 3'd2,
		REG_VCC_RISE  = 3'd3,
		REG_VIO_FALL  = 3'd4,
		REG_VIO_RISE  = 3'd5,
		REG_FILTER    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] vsup_mv;
		logic [SAMPLE_BITS-1:0] vcc_mv;
		logic [SAMPLE_BITS-1:0] vio_mv;
		logic [NOW_BITS-1:0]    now_ns;
		logic                   ack_pwron;
	} sample_t;

	typedef struct packed {
		logic vsup_uv;
		logic vcc_uv;
		logic vio_uv;
		logic power_on;
	} flags_t;

endpackage

@@ design/suvm_vsup_lane.sv @@
module suvm_vsup_lane
	import suvm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [SAMPLE_BITS-1:0] sample_mv,
	input  logic                   ack,
	input  logic [SAMPLE_BITS-1:0] fall_mv,
	input  logic [SAMPLE_BITS-1:0] rise_mv,
	output logic                   low_next,
	output logic                   pwr_next
);

	logic low_q;
	logic pwr_q;
	logic pwr_acked;

	assign pwr_acked = ack ? 1'b0 : pwr_q;

	always_comb begin
		low_next = low_q;
		pwr_next = pwr_acked;
		if (!low_q) begin
			low_next = (sample_mv <= fall_mv);
		end else if (sample_mv > rise_mv) begin
			low_next = 1'b0;
			pwr_next = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= 1'b0;
			pwr_q <= 1'b0;
		end else if (take) begin
			low_q <= low_next;
			pwr_q <= pwr_next;
		end
	end

endmodule

@@ design/suvm_rail_lane.sv @@
module suvm_rail_lane
	import suvm_pkg::*;
#(
	parameter logic [SAMPLE_BITS-1:0] LAST_INIT = VCC_LAST_RST
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [SAMPLE_BITS-1:0] sample_mv,
	input  logic [NOW_BITS-1:0]    now_ns,
	input  logic [SAMPLE_BITS-1:0] fall_mv,
	input  logic [SAMPLE_BITS-1:0] rise_mv,
	input  logic [FILTER_BITS-1:0] filter_ns,
	output logic                   low_next
);

	logic                   low_q;
	logic                   timing_q;
	logic [NOW_BITS-1:0]    start_q;
	logic [SAMPLE_BITS-1:0] last_q;

	logic                below;
	logic                above;
	logic                rising;
	logic [NOW_BITS-1:0] elapsed;
	logic                expired;

	assign below   = (sample_mv < fall_mv);
	assign above   = (sample_mv > rise_mv);
	assign rising  = (sample_mv > last_q);
	// modular elapsed time
	assign elapsed = now_ns - start_q;
	assign expired = timing_q
		? ({{(NOW_BITS-FILTER_BITS){1'b0}}, filter_ns} <= elapsed)
		: (filter_ns == '0);

	always_comb begin
		low_next = low_q;
		if (below) begin
			if (expired) begin
				low_next = 1'b1;
			end
		end else if (above) begin
			low_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q    <= 1'b0;
			timing_q <= 1'b0;
			start_q  <= '0;
			last_q   <= LAST_INIT;
		end else if (take) begin
			low_q  <= low_next;
			last_q <= sample_mv;
			if (below) begin
				if (!timing_q) begin
					timing_q <= 1'b1;
					start_q  <= now_ns;
				end
			end else if (above || rising) begin
				timing_q <= 1'b0;
			end
		end
	end

endmodule

@@ design/suvm_merge.sv @@
module suvm_merge
	import suvm_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   take,
	input  logic   vsup_uv,
	input  logic   vcc_uv,
	input  logic   vio_uv,
	input  logic   power_on,
	input  logic   out_stall,
	output logic   busy,
	output logic   out_valid,
	output flags_t out_flags
);

	flags_t res;
	flags_t out_q;
	flags_t skid_q;
	logic   out_valid_q;
	logic   skid_valid_q;

	always_comb begin
		res.vsup_uv  = vsup_uv;
		res.vcc_uv   = vcc_uv;
		res.vio_uv   = vio_uv;
		res.power_on = power_on;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= take;
			end
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (take) begin
			skid_q <= res;
		end
	end

	assign busy      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_flags = out_q;

endmodule

@@ design/supply_undervoltage_monitor_top.sv @@
// the flag result is registered and shows in the cycle after the sample transfer when the output is free
// throughput: one sample per cycle while sample_stall is low, state update of all rails done in that cycle
// a stalled result lets one more sample transfer into a second entry, then input stalls
// reset: arst_n asynchronous active low, clears lane flags, timers and buffer valid bits,
// thresholds and filter time return to their default values
module supply_undervoltage_monitor_top
	import suvm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sample_valid,
	output logic                     sample_stall,
	input  sample_t                  sample,
	output logic                     flag_valid,
	input  logic                     flag_stall,
	output flags_t                   flags,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	logic [SAMPLE_BITS-1:0] vsup_fall_q;
	logic [SAMPLE_BITS-1:0] vsup_rise_q;
	logic [SAMPLE_BITS-1:0] vcc_fall_q;
	logic [SAMPLE_BITS-1:0] vcc_rise_q;
	logic [SAMPLE_BITS-1:0] vio_fall_q;
	logic [SAMPLE_BITS-1:0] vio_rise_q;
	logic [FILTER_BITS-1:0] filter_q;

	logic take;
	logic busy;
	logic vsup_uv;
	logic pwr;
	logic vcc_uv;
	logic vio_uv;

	assign cfg_ready    = 1'b1;
	assign sample_stall = busy;
	assign take         = sample_valid && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vsup_fall_q <= VSUP_FALL_RST;
			vsup_rise_q <= VSUP_RISE_RST;
			vcc_fall_q  <= VCC_FALL_RST;
			vcc_rise_q  <= VCC_RISE_RST;
			vio_fall_q  <= VIO_FALL_RST;
			vio_rise_q  <= VIO_RISE_RST;
			filter_q    <= FILTER_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_VSUP_FALL: vsup_fall_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_VSUP_RISE: vsup_rise_q <= cfg_data[SAMPLE_BITS-1:0];
				REG_VCC_FALL:  vcc_fall_q  <= cfg_data[SAMPLE_BITS-1:0];
				REG_VCC_RISE:  vcc_rise_q  <= cfg_data[SAMPLE_BITS-1:0];
				REG_VIO_FALL:  vio_fall_q  <= cfg_data[SAMPLE_BITS-1:0];
				REG_VIO_RISE:  vio_rise_q  <= cfg_data[SAMPLE_BITS-1:0];
				REG_FILTER:    filter_q    <= cfg_data[FILTER_BITS-1:0];
				default: ;
			endcase
		end
	end

	suvm_vsup_lane u_vsup (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.sample_mv (sample.vsup_mv),
		.ack       (sample.ack_pwron),
		.fall_mv   (vsup_fall_q),
		.rise_mv   (vsup_rise_q),
		.low_next  (vsup_uv),
		.pwr_next  (pwr)
	);

	suvm_rail_lane #(
		.LAST_INIT (VCC_LAST_RST)
	) u_vcc (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.sample_mv (sample.vcc_mv),
		.now_ns    (sample.now_ns),
		.fall_mv   (vcc_fall_q),
		.rise_mv   (vcc_rise_q),
		.filter_ns (filter_q),
		.low_next  (vcc_uv)
	);

	suvm_rail_lane #(
		.LAST_INIT (VIO_LAST_RST)
	) u_vio (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.sample_mv (sample.vio_mv),
		.now_ns    (sample.now_ns),
		.fall_mv   (vio_fall_q),
		.rise_mv   (vio_rise_q),
		.filter_ns (filter_q),
		.low_next  (vio_uv)
	);

	suvm_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.vsup_uv   (vsup_uv),
		.vcc_uv    (vcc_uv),
		.vio_uv    (vio_uv),
		.power_on  (pwr),
		.out_stall (flag_stall),
		.busy      (busy),
		.out_valid (flag_valid),
		.out_flags (flags)
	);

endmodule

@@ design/suvm_checker.sv @@
module suvm_checker
	import suvm_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   sample_valid,
	input logic   sample_stall,
	input logic   flag_valid,
	input logic   flag_stall,
	input flags_t flags
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		flag_valid && flag_stall |=> flag_valid && $stable(flags))
		else $error("stalled result changed");

	// input stalls only with a result pending
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> flag_valid)
		else $error("input stalled with empty output");

	// empty output means free input next cycle
	a_free_after_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!flag_valid |=> !sample_stall)
		else $error("input stalled after empty output");

	// transfer into empty output shows next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && !flag_valid |=> flag_valid)
		else $error("missing result after transfer");

endmodule

bind supply_undervoltage_monitor_top suvm_checker u_suvm_checker (.*);
